[design/ica_pkg.sv]
// Shared types, codes and constants of the integer calculator ALU.
package ica_pkg;

  localparam int DATA_WIDTH_DEF  = 32;
  localparam int BINOM_MAX_N_DEF = 12;
  localparam int CMD_W           = 3;
  localparam int ST_W            = 2;
  // Every intermediate product of the binomial recurrence for n up to 20 fits here.
  localparam int BINOM_IW        = 24;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_POW   = 3'd4,
    OP_BINOM = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_RANGE = 2'd2
  } status_code_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_INIT,
    DP_MUL_STEP,
    DP_POW_INIT,
    DP_POW_MUL_INIT,
    DP_POW_UPDATE,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_BIN_INIT,
    DP_BIN_MUL_INIT,
    DP_BIN_DIV_INIT,
    DP_BIN_UPDATE,
    DP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] opcode;
    logic             b_zero;
    logic             binom_bad;
    logic             mul_done;
    logic             div_done;
    logic             exp_zero;
    logic             bin_done;
  } dp_stat_t;

  function automatic int imax(input int x, input int y);
    return (x > y) ? x : y;
  endfunction

endpackage

[design/integer_calculator_alu.sv]
// Integer calculator ALU: add, subtract, multiply, divide, power and binomial coefficient.
//
// The input channel (in_valid/in_ready) carries cmd, operand_a and operand_b; the output
// channel (out_valid/out_ready) carries result_value and status. Each input transaction
// produces exactly one output transaction. Items are worked on one at a time.
// Work per operation after dispatch (W = DATA_WIDTH, IW = max(W, 24)):
//   add, subtract, unused codes, divide by zero, binomial out of range: no iteration
//   multiply: shift-add multiplier, until the remaining bits of operand_b are zero
//   divide: restoring divider over all IW dividend bits
//   power: square-and-multiply, one multiplier pass per exponent bit up to the highest set bit
//   binomial: k rounds of a multiply by (n - i) and a divide by (i + 1)
// Multiplier (mul, pow, binom) and divider (div, binom) run one bit per cycle.
// in_ready returns high together with out_valid, so a new operation can start while the
// previous result waits in the output register. If the receiver stalls, a finished result
// is held back until the output register empties. Synchronous reset returns the
// controller to idle and clears out_valid; no result is pending after reset.
module integer_calculator_alu #(
  parameter int DATA_WIDTH  = ica_pkg::DATA_WIDTH_DEF,
  parameter int BINOM_MAX_N = ica_pkg::BINOM_MAX_N_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ica_pkg::CMD_W-1:0]     cmd,
  input  logic signed [DATA_WIDTH-1:0]  operand_a,
  input  logic signed [DATA_WIDTH-1:0]  operand_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]  result_value,
  output logic [ica_pkg::ST_W-1:0]      status
);
  import ica_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  ica_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  ica_dp #(
    .DATA_WIDTH  (DATA_WIDTH),
    .BINOM_MAX_N (BINOM_MAX_N)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .ctl          (ctl),
    .stat         (stat),
    .result_value (result_value),
    .status       (status)
  );

endmodule

[design/ica_dp.sv]
// Datapath of the integer calculator ALU: operand latch, shift-add multiplier,
// restoring divider, power and binomial registers, and the output register.
module ica_dp #(
  parameter int DATA_WIDTH  = ica_pkg::DATA_WIDTH_DEF,
  parameter int BINOM_MAX_N = ica_pkg::BINOM_MAX_N_DEF
) (
  input  logic                          clk,
  input  logic [ica_pkg::CMD_W-1:0]     cmd,
  input  logic signed [DATA_WIDTH-1:0]  operand_a,
  input  logic signed [DATA_WIDTH-1:0]  operand_b,
  input  ica_pkg::dp_cmd_t              ctl,
  output ica_pkg::dp_stat_t             stat,
  output logic signed [DATA_WIDTH-1:0]  result_value,
  output logic [ica_pkg::ST_W-1:0]      status
);
  import ica_pkg::*;

  localparam int IW    = imax(DATA_WIDTH, BINOM_IW);
  localparam int CNT_W = $clog2(IW + 1);
  localparam int IDX_W = $clog2(BINOM_MAX_N + 1);

  logic [CMD_W-1:0]      opcode;
  logic [DATA_WIDTH-1:0] opnd_a;
  logic [DATA_WIDTH-1:0] opnd_b;
  logic [DATA_WIDTH-1:0] expo;
  logic [IW-1:0]         acc;
  logic [IW-1:0]         sq;
  logic [IW-1:0]         m1;
  logic [IW-1:0]         m2;
  logic [IW-1:0]         mplier;
  logic [IW-1:0]         p1;
  logic [IW-1:0]         p2;
  logic [IW-1:0]         dvd;
  logic [IW-1:0]         dvs;
  logic [IW-1:0]         rem;
  logic [CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]      idx;

  logic                  a_neg;
  logic                  b_neg;
  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic                  binom_bad;
  logic [IDX_W-1:0]      n_minus_i;
  logic [IDX_W-1:0]      i_plus_1;
  logic [IW:0]           rem_sh;
  logic [IW:0]           rem_sub;
  logic                  div_ge;
  logic [IW-1:0]         quot_signed;

  assign a_neg     = opnd_a[DATA_WIDTH-1];
  assign b_neg     = opnd_b[DATA_WIDTH-1];
  assign mag_a     = a_neg ? (~opnd_a + 1'b1) : opnd_a;
  assign mag_b     = b_neg ? (~opnd_b + 1'b1) : opnd_b;
  assign binom_bad = a_neg | b_neg | (opnd_a > DATA_WIDTH'(BINOM_MAX_N)) | (opnd_b > opnd_a);
  assign n_minus_i = opnd_a[IDX_W-1:0] - idx;
  assign i_plus_1  = idx + 1'b1;

  // One restoring division step: bring down the next dividend bit.
  assign rem_sh      = {rem, dvd[IW-1]};
  assign div_ge      = (rem_sh >= {1'b0, dvs});
  assign rem_sub     = rem_sh - {1'b0, dvs};
  assign quot_signed = (a_neg ^ b_neg) ? (~dvd + 1'b1) : dvd;

  always_comb begin
    stat.opcode    = opcode;
    stat.b_zero    = (opnd_b == '0);
    stat.binom_bad = binom_bad;
    stat.mul_done  = (mplier == '0);
    stat.div_done  = (cnt == '0);
    stat.exp_zero  = (expo == '0);
    stat.bin_done  = (idx == opnd_b[IDX_W-1:0]);
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      DP_LOAD: begin
        opcode <= cmd;
        opnd_a <= operand_a;
        opnd_b <= operand_b;
      end
      DP_MUL_INIT: begin
        m1     <= IW'(opnd_a);
        mplier <= IW'(opnd_b);
        p1     <= '0;
      end
      DP_MUL_STEP: begin
        // Both products share the multiplier; the second one is the squaring for power.
        if (mplier[0]) begin
          p1 <= p1 + m1;
          p2 <= p2 + m2;
        end
        m1     <= m1 << 1;
        m2     <= m2 << 1;
        mplier <= mplier >> 1;
      end
      DP_POW_INIT: begin
        acc  <= IW'(1);
        sq   <= IW'(opnd_a);
        expo <= b_neg ? '0 : opnd_b;
      end
      DP_POW_MUL_INIT: begin
        m1     <= acc;
        m2     <= sq;
        mplier <= IW'(sq[DATA_WIDTH-1:0]);
        p1     <= '0;
        p2     <= '0;
      end
      DP_POW_UPDATE: begin
        if (expo[0]) begin
          acc <= p1;
        end
        sq   <= p2;
        expo <= expo >> 1;
      end
      DP_DIV_INIT: begin
        dvd <= IW'(mag_a);
        dvs <= IW'(mag_b);
        rem <= '0;
        cnt <= CNT_W'(IW);
      end
      DP_DIV_STEP: begin
        rem <= div_ge ? rem_sub[IW-1:0] : rem_sh[IW-1:0];
        dvd <= {dvd[IW-2:0], div_ge};
        cnt <= cnt - 1'b1;
      end
      DP_BIN_INIT: begin
        acc <= IW'(1);
        idx <= '0;
      end
      DP_BIN_MUL_INIT: begin
        m1     <= acc;
        mplier <= IW'(n_minus_i);
        p1     <= '0;
      end
      DP_BIN_DIV_INIT: begin
        dvd <= p1;
        dvs <= IW'(i_plus_1);
        rem <= '0;
        cnt <= CNT_W'(IW);
      end
      DP_BIN_UPDATE: begin
        acc <= dvd;
        idx <= idx + 1'b1;
      end
      DP_RESULT: begin
        unique case (opcode)
          OP_ADD: begin
            result_value <= opnd_a + opnd_b;
            status       <= ST_OK;
          end
          OP_SUB: begin
            result_value <= opnd_a - opnd_b;
            status       <= ST_OK;
          end
          OP_MUL: begin
            result_value <= p1[DATA_WIDTH-1:0];
            status       <= ST_OK;
          end
          OP_DIV: begin
            if (opnd_b == '0) begin
              result_value <= DATA_WIDTH'(1);
              status       <= ST_DIV0;
            end else begin
              result_value <= quot_signed[DATA_WIDTH-1:0];
              status       <= ST_OK;
            end
          end
          OP_POW: begin
            result_value <= acc[DATA_WIDTH-1:0];
            status       <= ST_OK;
          end
          OP_BINOM: begin
            if (binom_bad) begin
              result_value <= '0;
              status       <= ST_RANGE;
            end else begin
              result_value <= acc[DATA_WIDTH-1:0];
              status       <= ST_OK;
            end
          end
          default: begin
            result_value <= '0;
            status       <= ST_OK;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

[design/ica_ctrl.sv]
// Controller of the integer calculator ALU: sequences the datapath and runs the handshakes.
module ica_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ica_pkg::dp_stat_t   stat,
  output ica_pkg::dp_cmd_t    ctl
);
  import ica_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DISPATCH = 10'b0000000010,
    S_MUL      = 10'b0000000100,
    S_DIV      = 10'b0000001000,
    S_POW_LOOP = 10'b0000010000,
    S_POW_MUL  = 10'b0000100000,
    S_BIN_LOOP = 10'b0001000000,
    S_BIN_MUL  = 10'b0010000000,
    S_BIN_DIV  = 10'b0100000000,
    S_FINISH   = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;
  logic   issue;
  dp_op_t dp_op;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign ctl.op   = dp_op;
  assign out_valid_next = issue || (out_valid && !out_ready);

  always_comb begin
    state_next = state;
    dp_op      = DP_NOP;
    issue      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          dp_op      = DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.opcode)
          OP_MUL: begin
            dp_op      = DP_MUL_INIT;
            state_next = S_MUL;
          end
          OP_DIV: begin
            if (stat.b_zero) begin
              state_next = S_FINISH;
            end else begin
              dp_op      = DP_DIV_INIT;
              state_next = S_DIV;
            end
          end
          OP_POW: begin
            dp_op      = DP_POW_INIT;
            state_next = S_POW_LOOP;
          end
          OP_BINOM: begin
            if (stat.binom_bad) begin
              state_next = S_FINISH;
            end else begin
              dp_op      = DP_BIN_INIT;
              state_next = S_BIN_LOOP;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_MUL: begin
        if (stat.mul_done) begin
          state_next = S_FINISH;
        end else begin
          dp_op = DP_MUL_STEP;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_FINISH;
        end else begin
          dp_op = DP_DIV_STEP;
        end
      end
      S_POW_LOOP: begin
        if (stat.exp_zero) begin
          state_next = S_FINISH;
        end else begin
          dp_op      = DP_POW_MUL_INIT;
          state_next = S_POW_MUL;
        end
      end
      S_POW_MUL: begin
        if (stat.mul_done) begin
          dp_op      = DP_POW_UPDATE;
          state_next = S_POW_LOOP;
        end else begin
          dp_op = DP_MUL_STEP;
        end
      end
      S_BIN_LOOP: begin
        if (stat.bin_done) begin
          state_next = S_FINISH;
        end else begin
          dp_op      = DP_BIN_MUL_INIT;
          state_next = S_BIN_MUL;
        end
      end
      S_BIN_MUL: begin
        if (stat.mul_done) begin
          dp_op      = DP_BIN_DIV_INIT;
          state_next = S_BIN_DIV;
        end else begin
          dp_op = DP_MUL_STEP;
        end
      end
      S_BIN_DIV: begin
        if (stat.div_done) begin
          dp_op      = DP_BIN_UPDATE;
          state_next = S_BIN_LOOP;
        end else begin
          dp_op = DP_DIV_STEP;
        end
      end
      S_FINISH: begin
        // The result goes to the output register only once the previous one has left.
        if (out_free) begin
          dp_op      = DP_RESULT;
          issue      = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[design/ica_checker.sv]
// Port-level checker for the integer calculator ALU and its bind to the top level.
module ica_checker #(
  parameter int DATA_WIDTH = ica_pkg::DATA_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [DATA_WIDTH-1:0]  result_value,
  input logic [ica_pkg::ST_W-1:0]      status
);
  import ica_pkg::*;

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
    else $error("output transaction changed while stalled");

  // Only one operation is in flight: an accepted transaction closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while an operation was running");

  a_div0_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DIV0) |-> result_value == DATA_WIDTH'(1))
    else $error("divide by zero did not return one");

  a_range_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_RANGE) |-> result_value == '0)
    else $error("binomial range error did not return zero");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind integer_calculator_alu ica_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_ica_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_value (result_value),
  .status       (status)
);

[tb/tb_integer_calculator_alu.sv]
// Self-checking testbench for the integer calculator ALU with a built-in result predictor.
module tb_integer_calculator_alu;
  timeunit 1ns;
  timeprecision 1ps;

  import ica_pkg::*;

  localparam int W = 32;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 500;
  localparam int BINOM_N_MAX = 12;
  localparam logic [W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [W-1:0] VAL_MAX = 32'h7fff_ffff;
  // Opcodes outside the defined set; the block must answer them with zero.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [W-1:0] value;
    status_code_t st;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = '0;
  logic signed [W-1:0] operand_a = '0;
  logic signed [W-1:0] operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [W-1:0] result_value;
  logic [ST_W-1:0] status;

  alu_res_t pending_results[$];
  alu_res_t head_result;
  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_left = 0;
  int phase_cnt = 0;

  integer_calculator_alu DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_value(result_value),
    .status(status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic alu_res_t alu_result(input logic [CMD_W-1:0] c, input logic [W-1:0] a,
                                          input logic [W-1:0] b);
    alu_res_t r;
    logic [W-1:0] mag_a, mag_b, acc, sq, e;
    longint unsigned binom;
    r.value = '0;
    r.st = ST_OK;
    case (c)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      OP_DIV: begin
        if (b == '0) begin
          r.value = 1;
          r.st = ST_DIV0;
        end else begin
          mag_a = a[W-1] ? -a : a;
          mag_b = b[W-1] ? -b : b;
          r.value = mag_a / mag_b;
          if (a[W-1] != b[W-1]) r.value = -r.value;
        end
      end
      OP_POW: begin
        acc = 1;
        if (b != '0 && !b[W-1]) begin
          sq = a;
          e = b;
          while (e != '0) begin
            if (e[0]) acc = acc * sq;
            sq = sq * sq;
            e = e >> 1;
          end
        end
        r.value = acc;
      end
      OP_BINOM: begin
        if (a[W-1] || b[W-1] || a > BINOM_N_MAX || b > a) begin
          r.st = ST_RANGE;
        end else begin
          binom = 1;
          for (int i = 0; i < int'(b); i++) binom = binom * (a - i) / (i + 1);
          r.value = binom[W-1:0];
        end
      end
      default: r.value = '0;
    endcase
    return r;
  endfunction

  // Drives one transaction and records its expected result once it is accepted.
  task automatic send_op(input logic [CMD_W-1:0] c, input logic [W-1:0] a,
                         input logic [W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= c;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(alu_result(c, a, b));
  endtask

  function automatic logic [W-1:0] random_operand();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($urandom_range(0, 40)) - 32'd20;
      2: begin
        case ($urandom_range(0, 4))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          3: return '1;
          default: return 1;
        endcase
      end
      default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
    endcase
  endfunction

  task automatic test_add_sub();
    send_op(OP_ADD, VAL_MAX, 1);
    send_op(OP_ADD, VAL_MIN, '1);
    send_op(OP_SUB, VAL_MIN, 1);
    send_op(OP_SUB, '0, VAL_MIN);
  endtask

  task automatic test_multiply();
    send_op(OP_MUL, VAL_MAX, VAL_MAX);
    send_op(OP_MUL, VAL_MIN, '1);
    send_op(OP_MUL, -32'sd7, 32'sd6);
  endtask

  task automatic test_divide();
    send_op(OP_DIV, 32'sd7, '0);
    send_op(OP_DIV, VAL_MIN, '1);
    send_op(OP_DIV, -32'sd7, 32'sd2);
    send_op(OP_DIV, VAL_MAX, VAL_MIN);
  endtask

  task automatic test_power();
    send_op(OP_POW, 32'sd3, '0);
    send_op(OP_POW, 32'sd5, '1);
    send_op(OP_POW, 32'sd2, 32'sd31);
    send_op(OP_POW, -32'sd3, 32'sd5);
    // The longest exponent exercises the slowest path of the shared multiplier.
    send_op(OP_POW, 32'sd3, VAL_MAX);
  endtask

  task automatic test_binomial();
    send_op(OP_BINOM, 32'sd12, 32'sd6);
    send_op(OP_BINOM, '0, '0);
    send_op(OP_BINOM, 32'sd12, 32'sd12);
    send_op(OP_BINOM, 32'sd13, 32'sd1);
    send_op(OP_BINOM, 32'sd5, 32'sd6);
    send_op(OP_BINOM, '1, '0);
  endtask

  task automatic test_spare_codes();
    send_op(CMD_SPARE_LO, VAL_MAX, 32'sd9);
    send_op(CMD_SPARE_HI, VAL_MIN, '1);
  endtask

  task automatic test_random_mix(input int count);
    logic [CMD_W-1:0] c;
    logic [W-1:0] a, b;
    int pick;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 3) c = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
      else c = CMD_W'($urandom_range(0, 5));
      a = random_operand();
      b = random_operand();
      pick = $urandom_range(0, 9);
      case (c)
        OP_DIV: if (pick == 0) b = '0;
        OP_POW: begin
          // Mostly short exponents; long ones are slow and kept rare.
          if (pick < 6) b = $urandom_range(0, 40);
          else if (pick == 9) b = -32'($urandom_range(1, 8));
        end
        OP_BINOM: begin
          if (pick < 8) begin
            a = $urandom_range(0, BINOM_N_MAX);
            b = $urandom_range(0, a);
          end else begin
            a = 32'($urandom_range(0, 16)) - 32'd2;
            b = 32'($urandom_range(0, 16)) - 32'd2;
          end
        end
        default: ;
      endcase
      send_op(c, a, b);
    end
  endtask

  // Receiver: alternating stretches of steady acceptance and random stalls.
  always @(posedge clk) begin
    phase_cnt <= phase_cnt + 1;
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (phase_cnt[8] && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction: value %h status %0d",
                 $time, result_value, status);
        errors++;
      end else begin
        head_result = pending_results.pop_front();
        if (result_value !== head_result.value) begin
          $display("%0t: result_value mismatch: expected %h actual %h",
                   $time, head_result.value, result_value);
          errors++;
        end
        if (status !== head_result.st) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, head_result.st, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_integer_calculator_alu: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_add_sub();
    test_multiply();
    test_divide();
    test_power();
    test_binomial();
    test_spare_codes();
    test_random_mix(RANDOM_ITEMS);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_integer_calculator_alu: done, clean");
    end else begin
      $display("tb_integer_calculator_alu: done, errors");
    end
    $finish;
  end

endmodule
